// ===== sv/dbrcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dbrcs_pkg
// shared types and codes of the row column splitter
// ----------------------------------------------------------------------------
package dbrcs_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_DATA  = 2'd2;

   localparam logic [2:0] ROLE_ACK    = 3'd0;
   localparam logic [2:0] ROLE_BITMAP = 3'd1;
   localparam logic [2:0] ROLE_HEAD   = 3'd2;
   localparam logic [2:0] ROLE_VALUE  = 3'd3;
   localparam logic [2:0] ROLE_CHUNK  = 3'd4;
   localparam logic [2:0] ROLE_STRAY  = 3'd5;

   localparam logic [2:0] CLS_FIXED_LAST = 3'd3;
   localparam logic [2:0] CLS_WORD       = 3'd5;
   localparam logic [2:0] CLS_CHUNKED    = 3'd6;
   localparam logic [2:0] CLS_ODD        = 3'd7;

   localparam int          CSR_AW           = 2;
   localparam logic [1:0]  CSR_COLUMN_COUNT = 2'd0;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BITMAP,
      PH_HEAD,
      PH_VALUE,
      PH_CHUNKLEN,
      PH_CHUNKDATA
   } phase_type;

   typedef enum logic [1:0] {
      SQ_ACCEPT,
      SQ_SCAN,
      SQ_CHECK,
      SQ_LOAD
   } seq_type;

   typedef struct packed {
      logic [2:0] role;
      logic [7:0] column;
      logic [7:0] value;
      logic       done;
      logic       nul;
      logic       rowd;
   } rsp_type;

endpackage

// ===== sv/dbrcs_req_if.sv =====
// ----------------------------------------------------------------------------
// dbrcs_req_if
// input channel: opcode beats with class loads and row bytes
// ----------------------------------------------------------------------------
interface dbrcs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] column_index;
   logic [2:0] column_class;
   logic       row_has_bitmap;
   logic [7:0] data_byte;

   modport source (output valid, opcode, column_index, column_class, row_has_bitmap,
                   data_byte, input ready);
   modport sink (input valid, opcode, column_index, column_class, row_has_bitmap,
                 data_byte, output ready);
endinterface

// ===== sv/dbrcs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dbrcs_rsp_if
// result channel: one tagged beat per input beat
// ----------------------------------------------------------------------------
interface dbrcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] byte_role;
   logic [7:0] column_number;
   logic [7:0] value_byte;
   logic       column_done;
   logic       column_null;
   logic       row_done;

   modport source (output valid, byte_role, column_number, value_byte, column_done,
                   column_null, row_done, input ready);
   modport sink (input valid, byte_role, column_number, value_byte, column_done,
                 column_null, row_done, output ready);
endinterface

// ===== sv/dbrcs_ram.sv =====
// ----------------------------------------------------------------------------
// dbrcs_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module dbrcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/dbrcs_core.sv =====
// ----------------------------------------------------------------------------
// dbrcs_core
// parse sequencer over the class memory and the null bitmap memory
// ----------------------------------------------------------------------------
module dbrcs_core #(
   parameter int MAX_COLUMNS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [8:0] column_count,
   dbrcs_req_if.sink  req_chan,
   dbrcs_rsp_if.source rsp_chan
);
   localparam int LIMIT = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
   localparam int CAW   = (LIMIT > 1) ? $clog2(LIMIT) : 1;
   localparam int NDEP  = (LIMIT + 7) / 8;
   localparam int NAW   = (NDEP > 1) ? $clog2(NDEP) : 1;
   localparam logic [8:0] LIMIT_N = 9'(LIMIT);

   dbrcs_pkg::seq_type   st_ff, st_in;
   dbrcs_pkg::phase_type ph_ff, ph_in;
   logic [7:0]  col_ff, col_in;
   logic        bm_ff, bm_in;
   logic [3:0]  hp_ff, hp_in;
   logic [31:0] rem_ff, rem_in;
   logic        ones_ff, ones_in;
   logic [2:0]  cls_ff, cls_in;
   logic [8:0]  scan_ff, scan_in;
   dbrcs_pkg::rsp_type pend_ff, pend_in, out_ff, out_in;
   logic        ov_ff, ov_in;

   logic [8:0]  n_eff;
   logic        accept;
   logic        cls_we;
   logic [CAW-1:0] cls_raddr;
   logic [2:0]  cls_rdata;
   logic        nul_we;
   logic [NAW-1:0] nul_raddr;
   logic [7:0]  nul_rdata;
   logic [8:0]  base;
   logic [7:0]  hit;
   logic        found;
   logic [2:0]  first;
   logic [8:0]  found_col;
   logic [15:0] word_len;
   logic [31:0] rem_dec;
   logic [31:0] rem_chunk;
   logic [3:0]  hp_inc;
   logic        ones_new;
   logic [7:0]  b;

   assign n_eff = (column_count == 9'd0) ? 9'd1 :
                  ((column_count > LIMIT_N) ? LIMIT_N : column_count);
   assign b = req_chan.data_byte;

   assign req_chan.ready = (st_ff == dbrcs_pkg::SQ_ACCEPT) && (!ov_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   assign cls_we = accept && (req_chan.opcode == dbrcs_pkg::OP_LOAD) &&
                   ({1'b0, req_chan.column_index} < LIMIT_N);
   assign nul_we = accept && (req_chan.opcode == dbrcs_pkg::OP_DATA) &&
                   (ph_ff == dbrcs_pkg::PH_BITMAP);

   dbrcs_ram #(.WIDTH(3), .DEPTH(LIMIT)) u_class_ram (
      .clock   (clock),
      .wr_en   (cls_we),
      .wr_addr (req_chan.column_index[CAW-1:0]),
      .wr_data (req_chan.column_class),
      .rd_addr (cls_raddr),
      .rd_data (cls_rdata)
   );

   dbrcs_ram #(.WIDTH(8), .DEPTH(NDEP)) u_null_ram (
      .clock   (clock),
      .wr_en   (nul_we),
      .wr_addr (col_ff[3 +: NAW]),
      .wr_data (b),
      .rd_addr (nul_raddr),
      .rd_data (nul_rdata)
   );

   // null bitmap search within one word
   assign base = {scan_ff[8:3], 3'b000};
   always_comb begin
      for (int p = 0; p < 8; p++) begin
         hit[p] = (3'(p) >= scan_ff[2:0]) && ((base + 9'(p)) < n_eff) && !nul_rdata[p];
      end
   end
   always_comb begin
      found = 1'b0;
      first = 3'd0;
      for (int p = 7; p >= 0; p--) begin
         if (hit[p]) begin
            found = 1'b1;
            first = 3'(p);
         end
      end
   end
   assign found_col = base + {6'd0, first};

   assign nul_raddr = scan_ff[3 +: NAW];
   assign cls_raddr = (st_ff == dbrcs_pkg::SQ_CHECK) ? found_col[CAW-1:0] :
                      scan_ff[CAW-1:0];

   assign word_len  = {b, rem_ff[7:0]};
   assign rem_dec   = rem_ff - ((rem_ff != 32'd0) ? 32'd1 : 32'd0);
   assign rem_chunk = rem_ff | (32'(b) << {hp_ff[1:0], 3'b000});
   assign hp_inc    = hp_ff + 4'd1;
   assign ones_new  = ones_ff && (b == 8'hFF);

   always_comb begin
      st_in   = st_ff;
      ph_in   = ph_ff;
      col_in  = col_ff;
      bm_in   = bm_ff;
      hp_in   = hp_ff;
      rem_in  = rem_ff;
      ones_in = ones_ff;
      cls_in  = cls_ff;
      scan_in = scan_ff;
      pend_in = pend_ff;
      out_in  = out_ff;
      ov_in   = ov_ff && !rsp_chan.ready;

      case (st_ff)
         dbrcs_pkg::SQ_ACCEPT: begin
            if (accept) begin
               out_in = '{role: dbrcs_pkg::ROLE_ACK, column: 8'd0, value: 8'd0,
                          done: 1'b0, nul: 1'b0, rowd: 1'b0};
               ov_in  = 1'b1;
               case (req_chan.opcode)
                  dbrcs_pkg::OP_LOAD: begin
                     out_in.column = req_chan.column_index;
                     if (cls_we && (req_chan.column_index == col_ff)) begin
                        cls_in = req_chan.column_class;
                     end
                  end
                  dbrcs_pkg::OP_START: begin
                     bm_in   = req_chan.row_has_bitmap;
                     col_in  = 8'd0;
                     hp_in   = 4'd0;
                     rem_in  = 32'd0;
                     ones_in = 1'b1;
                     if (req_chan.row_has_bitmap) begin
                        ph_in = dbrcs_pkg::PH_BITMAP;
                     end else begin
                        pend_in = out_in;
                        ov_in   = 1'b0;
                        scan_in = 9'd0;
                        st_in   = dbrcs_pkg::SQ_SCAN;
                     end
                  end
                  dbrcs_pkg::OP_DATA: begin
                     out_in.column = col_ff;
                     out_in.value  = b;
                     case (ph_ff)
                        dbrcs_pkg::PH_BITMAP: begin
                           out_in.role = dbrcs_pkg::ROLE_BITMAP;
                           if (({1'b0, col_ff} + 9'd8) >= n_eff) begin
                              pend_in = out_in;
                              ov_in   = 1'b0;
                              scan_in = 9'd0;
                              st_in   = dbrcs_pkg::SQ_SCAN;
                           end else begin
                              col_in = col_ff + 8'd8;
                           end
                        end
                        dbrcs_pkg::PH_HEAD: begin
                           out_in.role = dbrcs_pkg::ROLE_HEAD;
                           if (cls_ff == dbrcs_pkg::CLS_WORD) begin
                              if (hp_ff == 4'd0) begin
                                 rem_in = 32'(b);
                                 hp_in  = 4'd1;
                              end else begin
                                 rem_in = 32'(word_len);
                                 if (word_len == 16'hFFFF || word_len == 16'd0) begin
                                    out_in.done = 1'b1;
                                    out_in.nul  = (word_len == 16'hFFFF);
                                 end else begin
                                    ph_in = dbrcs_pkg::PH_VALUE;
                                 end
                              end
                           end else if (cls_ff == dbrcs_pkg::CLS_CHUNKED) begin
                              ones_in = ones_new;
                              hp_in   = hp_inc;
                              if (hp_inc >= 4'd8) begin
                                 if (ones_new) begin
                                    out_in.done = 1'b1;
                                    out_in.nul  = 1'b1;
                                 end else begin
                                    ph_in  = dbrcs_pkg::PH_CHUNKLEN;
                                    hp_in  = 4'd0;
                                    rem_in = 32'd0;
                                 end
                              end
                           end else begin
                              if (b == 8'd0) begin
                                 out_in.done = 1'b1;
                                 out_in.nul  = !bm_ff;
                              end else begin
                                 rem_in = 32'(b);
                                 ph_in  = dbrcs_pkg::PH_VALUE;
                              end
                           end
                        end
                        dbrcs_pkg::PH_VALUE: begin
                           out_in.role = dbrcs_pkg::ROLE_VALUE;
                           rem_in      = rem_dec;
                           out_in.done = (rem_dec == 32'd0);
                        end
                        dbrcs_pkg::PH_CHUNKLEN: begin
                           out_in.role = dbrcs_pkg::ROLE_CHUNK;
                           rem_in      = rem_chunk;
                           hp_in       = hp_inc;
                           if (hp_inc >= 4'd4) begin
                              hp_in = 4'd0;
                              if (rem_chunk == 32'd0) begin
                                 out_in.done = 1'b1;
                              end else begin
                                 ph_in = dbrcs_pkg::PH_CHUNKDATA;
                              end
                           end
                        end
                        dbrcs_pkg::PH_CHUNKDATA: begin
                           out_in.role = dbrcs_pkg::ROLE_VALUE;
                           rem_in      = rem_dec;
                           if (rem_dec == 32'd0) begin
                              ph_in = dbrcs_pkg::PH_CHUNKLEN;
                              hp_in = 4'd0;
                           end
                        end
                        default: begin
                           out_in.role   = dbrcs_pkg::ROLE_STRAY;
                           out_in.column = 8'd0;
                        end
                     endcase
                     if (out_in.done) begin
                        pend_in = out_in;
                        ov_in   = 1'b0;
                        scan_in = {1'b0, col_ff} + 9'd1;
                        st_in   = dbrcs_pkg::SQ_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         dbrcs_pkg::SQ_SCAN: begin
            if (scan_ff >= n_eff) begin
               ph_in       = dbrcs_pkg::PH_IDLE;
               col_in      = 8'd0;
               hp_in       = 4'd0;
               rem_in      = 32'd0;
               ones_in     = 1'b1;
               out_in      = pend_ff;
               out_in.rowd = 1'b1;
               ov_in       = 1'b1;
               st_in       = dbrcs_pkg::SQ_ACCEPT;
            end else if (!bm_ff) begin
               st_in = dbrcs_pkg::SQ_LOAD;
            end else begin
               st_in = dbrcs_pkg::SQ_CHECK;
            end
         end
         dbrcs_pkg::SQ_CHECK: begin
            if (found) begin
               scan_in = found_col;
               st_in   = dbrcs_pkg::SQ_LOAD;
            end else begin
               scan_in = base + 9'd8;
               st_in   = dbrcs_pkg::SQ_SCAN;
            end
         end
         dbrcs_pkg::SQ_LOAD: begin
            col_in  = scan_ff[7:0];
            cls_in  = cls_rdata;
            hp_in   = 4'd0;
            ones_in = 1'b1;
            if (cls_rdata <= dbrcs_pkg::CLS_FIXED_LAST) begin
               ph_in  = dbrcs_pkg::PH_VALUE;
               rem_in = 32'(4'b0001 << cls_rdata[1:0]);
            end else if (cls_rdata == dbrcs_pkg::CLS_ODD) begin
               ph_in  = dbrcs_pkg::PH_VALUE;
               rem_in = 32'd1;
            end else begin
               ph_in  = dbrcs_pkg::PH_HEAD;
               rem_in = 32'd0;
            end
            out_in = pend_ff;
            ov_in  = 1'b1;
            st_in  = dbrcs_pkg::SQ_ACCEPT;
         end
         default: begin
            st_in = dbrcs_pkg::SQ_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= dbrcs_pkg::SQ_ACCEPT;
         ph_ff   <= dbrcs_pkg::PH_IDLE;
         col_ff  <= 8'd0;
         bm_ff   <= 1'b0;
         hp_ff   <= 4'd0;
         rem_ff  <= 32'd0;
         ones_ff <= 1'b1;
         ov_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         ph_ff   <= ph_in;
         col_ff  <= col_in;
         bm_ff   <= bm_in;
         hp_ff   <= hp_in;
         rem_ff  <= rem_in;
         ones_ff <= ones_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff  <= cls_in;
      scan_ff <= scan_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid         = ov_ff;
   assign rsp_chan.byte_role     = out_ff.role;
   assign rsp_chan.column_number = out_ff.column;
   assign rsp_chan.value_byte    = out_ff.value;
   assign rsp_chan.column_done   = out_ff.done;
   assign rsp_chan.column_null   = out_ff.nul;
   assign rsp_chan.row_done      = out_ff.rowd;
endmodule

// ===== sv/db_row_column_splitter.sv =====
// ----------------------------------------------------------------------------
// db_row_column_splitter
// splits result row bytes into tagged column value bytes
// ----------------------------------------------------------------------------
// req_chan takes one beat per cycle when ready: class loads, row starts and row bytes.
// rsp_chan returns exactly one tagged beat per request beat, in order.
// csr_ is an apb register port holding column_count at byte address 0.
// a beat that does not end a column is answered in the cycle after it is taken
// and, while rsp_chan is ready, the next beat can follow at once, so row bytes
// stream at one per cycle. a beat that ends a column, a non-bitmap row start
// and the last bitmap byte start a walk to the next column that carries bytes:
// a scan and a load step for a plain row, in a bitmap row a scan and a check step
// per 8-column bitmap word searched plus a load step for the class memory read.
// the answer of such a beat appears when the walk is over, with row_done set
// when no column is left.
// reset clears the parse state and the null bitmap use; column classes must
// be loaded before a row uses them. when rsp_chan stalls, the result is held
// and req_chan.ready drops until it is taken.
// ----------------------------------------------------------------------------
module db_row_column_splitter #(
   parameter int MAX_COLUMNS = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   dbrcs_req_if.sink                  req_chan,
   dbrcs_rsp_if.source                rsp_chan,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [dbrcs_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   logic [8:0] cc_ff, cc_in;
   logic       cc_hit;

   assign csr_pready = 1'b1;
   assign cc_hit     = (csr_paddr == dbrcs_pkg::CSR_COLUMN_COUNT);

   always_comb begin
      cc_in = cc_ff;
      if (csr_psel && csr_penable && csr_pwrite && cc_hit) begin
         cc_in = csr_pwdata[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= 9'd1;
      end else begin
         cc_ff <= cc_in;
      end
   end

   assign csr_prdata = cc_hit ? {23'd0, cc_ff} : 32'd0;

   dbrcs_core #(.MAX_COLUMNS(MAX_COLUMNS)) u_core (
      .clock        (clock),
      .reset        (reset),
      .column_count (cc_ff),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan)
   );
endmodule
